// ===== rtl/ohsb_pkg.sv =====
`default_nettype none

package ohsb_pkg;

  // Field widths
  localparam int ANGLE_W     = 15;
  localparam int MAG_W       = 16;
  localparam int BIN_INDEX_W = 3;
  localparam int ACC_W       = 40;

  // Default histogram size
  localparam int NUM_BINS_DEF = 8;

  // Angle units: full circle in 1/64 degree, and half of it in scaled units
  localparam int ANGLE_FULL = 23040;
  localparam int HALF_OFF   = 11520;

  // Division by ANGLE_FULL = 2^9 * 45: shift, then reciprocal multiply by 1/45
  localparam int DIV_SH  = 9;
  localparam int DIV_ODD = 45;

  // Bin quotient: exact reciprocal, ceil(2^20/45), for dividends below 2^11
  localparam int REC_Q    = 23302;
  localparam int REC_Q_W  = 15;
  localparam int REC_Q_SH = 20;

  // Share quotient: floor(2^22/45), may be one low, fixed by one compare
  localparam int REC_S    = 93206;
  localparam int REC_S_SH = 22;

  // Share weight (HALF_OFF..ANGLE_FULL) and magnitude times weight
  localparam int WGT_W  = 15;
  localparam int PROD_W = MAG_W + WGT_W;
  localparam int Y_W    = PROD_W - DIV_SH;
  localparam int QS_W   = Y_W + 17 - REC_S_SH + 22 - Y_W;  // 17-bit share quotient

  localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

endpackage : ohsb_pkg

`default_nettype wire

// ===== rtl/ohsb_pix_if.sv =====
`default_nettype none

// Gradient pixel item channel
interface ohsb_pix_if;
  logic                          valid;
  logic                          ready;
  logic [ohsb_pkg::ANGLE_W-1:0]  angle;
  logic [ohsb_pkg::MAG_W-1:0]    magnitude;
  logic                          last_pixel;

  modport source (output valid, output angle, output magnitude, output last_pixel,
                  input ready);
  modport sink   (input valid, input angle, input magnitude, input last_pixel,
                  output ready);
endinterface : ohsb_pix_if

`default_nettype wire

// ===== rtl/ohsb_bin_if.sv =====
`default_nettype none

// Histogram bin item channel
interface ohsb_bin_if;
  logic                              valid;
  logic                              ready;
  logic [ohsb_pkg::BIN_INDEX_W-1:0]  bin_index;
  logic [ohsb_pkg::ACC_W-1:0]        bin_value;
  logic                              last_bin;

  modport source (output valid, output bin_index, output bin_value, output last_bin,
                  input ready);
  modport sink   (input valid, input bin_index, input bin_value, input last_bin,
                  output ready);
endinterface : ohsb_bin_if

`default_nettype wire

// ===== rtl/orientation_histogram_soft_binning.sv =====
`default_nettype none

// Channel   Dir  Payload                                   Handshake
// in_pix    in   angle[15], magnitude[16], last_pixel[1]   valid/ready
// out_bin   out  bin_index[3], bin_value[40], last_bin[1]  valid/ready
// cfg       in   cfg_wdata[1] = weighted_mode              cfg_we, no wait
//
// One pixel item per cycle unless held. A taken pixel passes the stage
// registers to the accumulators. A last pixel copies the bins (with its
// own share) into a readout bank and clears them; the bank then sends
// NUM_BINS items, one per cycle while out_bin.ready is high. A further last
// pixel reaching the accumulators before the bank drains holds every stage.
// Reset (rst_n low, synchronous) clears the bins and sets weighted_mode.

module orientation_histogram_soft_binning #(
  parameter int NUM_BINS = ohsb_pkg::NUM_BINS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_wdata,
  ohsb_pix_if.sink         in_pix,
  ohsb_bin_if.source       out_bin
);

  localparam int IDX_W = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int Q_W   = $clog2(NUM_BINS + 1);
  localparam int X_W   = $clog2(ohsb_pkg::ANGLE_FULL * NUM_BINS + ohsb_pkg::HALF_OFF);
  localparam int XY_W  = X_W - ohsb_pkg::DIV_SH;
  localparam int QP_W  = XY_W + ohsb_pkg::REC_Q_W;
  localparam int R_W   = 15;
  localparam int SP_W  = ohsb_pkg::Y_W + 17;
  localparam int S_W   = 17;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_BINS - 1);

  // Config register
  logic weighted_r;

  // Pipeline valids and control
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic last1_r, last2_r, last3_r, last4_r, last5_r, last6_r;
  logic adv;
  logic bank_free;
  logic load;

  // Stage payloads
  logic [X_W-1:0]                 x1_r, x2_r;
  logic [Q_W-1:0]                 q2_r;
  logic [ohsb_pkg::MAG_W-1:0]     mag1_r, mag2_r, mag3_r, mag4_r, mag5_r, mag6_r;
  logic [IDX_W-1:0]               main3_r, main4_r, main5_r, main6_r;
  logic [IDX_W-1:0]               side3_r, side4_r, side5_r, side6_r;
  logic [ohsb_pkg::WGT_W-1:0]     w3_r;
  logic [ohsb_pkg::PROD_W-1:0]    p4_r;
  logic [ohsb_pkg::Y_W-1:0]       y5_r, y6_r;
  logic [S_W-1:0]                 q6_r;

  // Next values
  logic [ohsb_pkg::ANGLE_W-1:0]   a_wrap;
  logic [X_W-1:0]                 x1_nxt;
  logic [QP_W-1:0]                qprod;
  logic [Q_W-1:0]                 q2_nxt;
  logic [X_W-1:0]                 qbase;
  logic [R_W-1:0]                 rem;
  logic                           upper;
  logic [R_W-1:0]                 absd;
  logic [IDX_W-1:0]               qidx;
  logic [IDX_W-1:0]               main3_nxt, side3_nxt;
  logic [ohsb_pkg::WGT_W-1:0]     w3_nxt;
  logic [ohsb_pkg::PROD_W-1:0]    p4_nxt;
  logic [SP_W-1:0]                sprod;
  logic [S_W-1:0]                 q6_nxt;
  logic [ohsb_pkg::Y_W:0]         srem;
  logic [S_W-1:0]                 share_full;
  logic [ohsb_pkg::MAG_W-1:0]     share;
  logic [ohsb_pkg::MAG_W-1:0]     main_share, side_share;

  // Bins and readout bank
  logic [ohsb_pkg::ACC_W-1:0]     acc_r  [NUM_BINS];
  logic [ohsb_pkg::ACC_W-1:0]     acc_nxt[NUM_BINS];
  logic [ohsb_pkg::ACC_W-1:0]     bank_r [NUM_BINS];
  logic                           busy_r;
  logic [IDX_W-1:0]               cnt_r;

  // Flow control: only a last pixel meeting a full bank holds the pipe
  assign bank_free = !busy_r || (out_bin.ready && (cnt_r == IDX_LAST));
  assign adv       = !(v6_r && last6_r && !bank_free);
  assign load      = adv && v6_r && last6_r;
  assign in_pix.ready = adv && rst_n;

  // Stage 1 input: wrap angle, scale to x = a*N + half bin offset
  always_comb begin
    if (in_pix.angle >= ohsb_pkg::ANGLE_W'(ohsb_pkg::ANGLE_FULL)) begin
      a_wrap = in_pix.angle - ohsb_pkg::ANGLE_W'(ohsb_pkg::ANGLE_FULL);
    end else begin
      a_wrap = in_pix.angle;
    end
    x1_nxt = X_W'(a_wrap) * X_W'(NUM_BINS) + X_W'(ohsb_pkg::HALF_OFF);
  end

  // Stage 2: nearest-bin quotient q = x / 23040
  assign qprod  = QP_W'(x1_r[X_W-1:ohsb_pkg::DIV_SH]) * QP_W'(ohsb_pkg::REC_Q);
  assign q2_nxt = qprod[ohsb_pkg::REC_Q_SH +: Q_W];

  // Stage 3: offset from bin center, neighbor bin, main weight
  always_comb begin
    qbase = X_W'(q2_r) * X_W'(ohsb_pkg::ANGLE_FULL);
    rem   = R_W'(x2_r - qbase);
    upper = rem >= R_W'(ohsb_pkg::HALF_OFF);
    if (upper) begin
      absd = rem - R_W'(ohsb_pkg::HALF_OFF);
    end else begin
      absd = R_W'(ohsb_pkg::HALF_OFF) - rem;
    end
    w3_nxt = ohsb_pkg::WGT_W'(ohsb_pkg::ANGLE_FULL) - ohsb_pkg::WGT_W'(absd);
    // q == N wraps to bin 0
    if (q2_r == Q_W'(NUM_BINS)) begin
      qidx = '0;
    end else begin
      qidx = IDX_W'(q2_r);
    end
    main3_nxt = qidx;
    if (upper) begin
      side3_nxt = (qidx == IDX_LAST) ? '0 : qidx + 1'b1;
    end else begin
      side3_nxt = (qidx == '0) ? IDX_LAST : qidx - 1'b1;
    end
    // Upper edge of bin 0 stays in bin 0
    if ((q2_r == Q_W'(1)) && (rem == '0)) begin
      main3_nxt = '0;
      side3_nxt = IDX_W'(1);
    end
  end

  // Stage 4: magnitude times weight
  assign p4_nxt = ohsb_pkg::PROD_W'(mag3_r) * ohsb_pkg::PROD_W'(w3_r);

  // Stage 5: approximate share = p / 23040, may be one low
  assign sprod  = SP_W'(y5_r) * SP_W'(ohsb_pkg::REC_S);
  assign q6_nxt = sprod[ohsb_pkg::REC_S_SH +: S_W];

  // Stage 6: correct quotient, form shares
  always_comb begin
    srem = (ohsb_pkg::Y_W + 1)'(y6_r)
         - (ohsb_pkg::Y_W + 1)'(q6_r) * (ohsb_pkg::Y_W + 1)'(ohsb_pkg::DIV_ODD);
    if (srem >= (ohsb_pkg::Y_W + 1)'(ohsb_pkg::DIV_ODD)) begin
      share_full = q6_r + 1'b1;
    end else begin
      share_full = q6_r;
    end
    share = ohsb_pkg::MAG_W'(share_full);
    if (weighted_r) begin
      main_share = share;
      side_share = mag6_r - share;
    end else begin
      main_share = mag6_r;
      side_share = '0;
    end
  end

  // Saturating add into each bin; main and side never coincide
  always_comb begin
    logic [ohsb_pkg::MAG_W-1:0] add;
    logic [ohsb_pkg::ACC_W:0]   sum;
    for (int i = 0; i < NUM_BINS; i++) begin
      add = '0;
      if (main6_r == IDX_W'(i)) begin
        add = main_share;
      end
      if (side6_r == IDX_W'(i)) begin
        add = add | side_share;
      end
      sum = (ohsb_pkg::ACC_W + 1)'(acc_r[i]) + (ohsb_pkg::ACC_W + 1)'(add);
      if (sum[ohsb_pkg::ACC_W]) begin
        acc_nxt[i] = ohsb_pkg::ACC_MAX;
      end else begin
        acc_nxt[i] = sum[ohsb_pkg::ACC_W-1:0];
      end
    end
  end

  // Control state, config and bins
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weighted_r <= 1'b1;
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0;
      v4_r <= 1'b0; v5_r <= 1'b0; v6_r <= 1'b0;
      busy_r <= 1'b0;
      cnt_r  <= '0;
      for (int i = 0; i < NUM_BINS; i++) begin
        acc_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        weighted_r <= cfg_wdata;
      end
      if (adv) begin
        v1_r <= in_pix.valid;
        v2_r <= v1_r;
        v3_r <= v2_r;
        v4_r <= v3_r;
        v5_r <= v4_r;
        v6_r <= v5_r;
        if (v6_r) begin
          for (int i = 0; i < NUM_BINS; i++) begin
            acc_r[i] <= last6_r ? '0 : acc_nxt[i];
          end
        end
      end
      // Readout counter
      if (load) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r && out_bin.ready) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == IDX_LAST) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // Pipeline payload
  always_ff @(posedge clk) begin
    if (adv) begin
      x1_r    <= x1_nxt;
      mag1_r  <= in_pix.magnitude;
      last1_r <= in_pix.last_pixel;

      x2_r    <= x1_r;
      q2_r    <= q2_nxt;
      mag2_r  <= mag1_r;
      last2_r <= last1_r;

      main3_r <= main3_nxt;
      side3_r <= side3_nxt;
      w3_r    <= w3_nxt;
      mag3_r  <= mag2_r;
      last3_r <= last2_r;

      p4_r    <= p4_nxt;
      main4_r <= main3_r;
      side4_r <= side3_r;
      mag4_r  <= mag3_r;
      last4_r <= last3_r;

      y5_r    <= p4_r[ohsb_pkg::PROD_W-1:ohsb_pkg::DIV_SH];
      main5_r <= main4_r;
      side5_r <= side4_r;
      mag5_r  <= mag4_r;
      last5_r <= last4_r;

      y6_r    <= y5_r;
      q6_r    <= q6_nxt;
      main6_r <= main5_r;
      side6_r <= side5_r;
      mag6_r  <= mag5_r;
      last6_r <= last5_r;
    end
  end

  // Readout bank: snapshot on a last pixel, shift toward entry 0 per item
  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < NUM_BINS; i++) begin
        bank_r[i] <= acc_nxt[i];
      end
    end else if (busy_r && out_bin.ready) begin
      for (int i = 0; i < NUM_BINS - 1; i++) begin
        bank_r[i] <= bank_r[i+1];
      end
    end
  end

  // Result channel
  assign out_bin.valid     = busy_r;
  assign out_bin.bin_index = ohsb_pkg::BIN_INDEX_W'(cnt_r);
  assign out_bin.bin_value = bank_r[0];
  assign out_bin.last_bin  = (cnt_r == IDX_LAST);

endmodule : orientation_histogram_soft_binning

`default_nettype wire

// ===== tb/testbench.sv =====
module testbench;

  // Field widths and constants from the package
  localparam int ANGLE_W      = ohsb_pkg::ANGLE_W;
  localparam int MAG_W        = ohsb_pkg::MAG_W;
  localparam int BIN_INDEX_W  = ohsb_pkg::BIN_INDEX_W;
  localparam int ACC_W        = ohsb_pkg::ACC_W;
  localparam int NUM_BINS_DEF = ohsb_pkg::NUM_BINS_DEF;
  localparam int ANGLE_FULL   = ohsb_pkg::ANGLE_FULL;
  localparam logic [ACC_W-1:0] ACC_MAX = ohsb_pkg::ACC_MAX;

  // Histogram geometry in scaled angle units (angle * 2 * bins)
  localparam int NB       = NUM_BINS_DEF;
  localparam int SCALE    = 2 * NB;
  localparam int HALF_SEC = ANGLE_FULL;
  localparam int SEC_W    = 2 * HALF_SEC;
  localparam int CIRCLE   = HALF_SEC * SCALE;

  // Binning modes
  localparam logic MODE_NEAREST = 1'b0;
  localparam logic MODE_SPLIT   = 1'b1;

  localparam int DRAIN      = 12;    // pipeline is six deep, keep a margin
  localparam int WD_LIMIT   = 2000;  // cycles with no item moving
  localparam int RAND_ITEMS = 460;
  localparam int CALM_ITEMS = 70;    // tail of the run without idling

  typedef struct packed {
    logic [BIN_INDEX_W-1:0] idx;
    logic [ACC_W-1:0]       val;
    logic                   lst;
  } bin_item_t;

  // Directed rows; lit marks a readout whose one nonzero bin is typed in
  typedef struct packed {
    logic                   mode;
    logic [ANGLE_W-1:0]     ang;
    logic [MAG_W-1:0]       mag;
    logic                   lst;
    logic                   lit;
    logic [BIN_INDEX_W-1:0] lit_bin;
    logic [ACC_W-1:0]       lit_val;
  } row_t;

  localparam int NROWS = 19;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;
  bit   calm;

  ohsb_pix_if pix_ch ();
  ohsb_bin_if bin_ch ();

  orientation_histogram_soft_binning #(.NUM_BINS(NB)) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_pix   (pix_ch.sink),
    .out_bin  (bin_ch.source)
  );

  // Predictor state
  logic [ACC_W-1:0] hist [NB];
  logic             mode_q;
  bin_item_t        bins_due [$];

  int errs;
  int pixels;
  int bins_seen;
  int split_reads;
  int near_reads;

  row_t dir_tab [NROWS];

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Saturating add into one bin
  function automatic void acc_add(input int unsigned b, input longint unsigned v);
    logic [ACC_W:0] sum;
    sum = {1'b0, hist[b]} + (ACC_W+1)'(v);
    if (sum > {1'b0, ACC_MAX}) begin
      hist[b] = ACC_MAX;
    end else begin
      hist[b] = sum[ACC_W-1:0];
    end
  endfunction

  // Bin one accepted pixel; a last pixel queues the whole readout and clears
  function automatic void bin_pixel(input logic [ANGLE_W-1:0] ang,
                                    input logic [MAG_W-1:0] mag, input logic lst);
    int unsigned a, s, dif, ctr, near_b, side_b;
    longint unsigned m64, near_amt;
    bin_item_t it;
    a = ang;
    m64 = mag;
    if (a >= ANGLE_FULL) a -= ANGLE_FULL;
    s = a * SCALE;
    // bin 0 straddles the wrap, so both of its halves are handled apart
    if (s <= HALF_SEC) begin
      near_b = 0;
      side_b = 1;
      dif = s;
    end else if (s >= (SCALE - 1) * HALF_SEC) begin
      near_b = 0;
      side_b = NB - 1;
      dif = CIRCLE - s;
    end else begin
      near_b = (s - HALF_SEC) / SEC_W + 1;
      ctr = near_b * SEC_W;
      if (s >= ctr) begin
        dif = s - ctr;
        side_b = (near_b == NB - 1) ? 0 : near_b + 1;
      end else begin
        dif = ctr - s;
        side_b = near_b - 1;
      end
    end
    if (mode_q == MODE_SPLIT) begin
      if (dif > HALF_SEC) dif = HALF_SEC;
      near_amt = (m64 * (SEC_W - dif)) / SEC_W;
      acc_add(near_b, near_amt);
      acc_add(side_b, m64 - near_amt);
    end else begin
      acc_add(near_b, m64);
    end
    pixels++;
    if (lst) begin
      for (int i = 0; i < NB; i++) begin
        it.idx = BIN_INDEX_W'(i);
        it.val = hist[i];
        it.lst = (i == NB - 1);
        bins_due = {bins_due, it};
        hist[i] = '0;
      end
      if (mode_q == MODE_SPLIT) split_reads++;
      else near_reads++;
    end
  endfunction

  // Offer one pixel item and hold it until taken
  task automatic push_pixel(input logic [ANGLE_W-1:0] ang, input logic [MAG_W-1:0] mag,
                            input logic lst);
    bit hit;
    pix_ch.valid      <= 1'b1;
    pix_ch.angle      <= ang;
    pix_ch.magnitude  <= mag;
    pix_ch.last_pixel <= lst;
    do begin
      @(negedge clk);
      hit = pix_ch.ready;
      @(posedge clk);
    end while (!hit);
    bin_pixel(ang, mag, lst);
  endtask

  // Sender gap with junk payload
  task automatic idle_for(input int n);
    pix_ch.valid      <= 1'b0;
    pix_ch.angle      <= ANGLE_W'($urandom);
    pix_ch.magnitude  <= MAG_W'($urandom);
    pix_ch.last_pixel <= 1'($urandom);
    repeat (n) @(posedge clk);
  endtask

  // Drain everything, then write the mode register
  task automatic settle_mode(input logic m);
    pix_ch.valid <= 1'b0;
    while (bins_due.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    mode_q = m;
  endtask

  // Receiver: stall bursts between ready stretches
  initial begin
    bin_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        bin_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
      bin_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
  end

  // Bin item checker, sampled mid-cycle where all signals are settled
  always @(negedge clk) begin
    bin_item_t want;
    if (rst_n && bin_ch.valid && bin_ch.ready) begin
      if (bins_due.size() == 0) begin
        $error("unexpected bin item: bin_index %0d bin_value %0d", bin_ch.bin_index,
               bin_ch.bin_value);
        errs++;
      end else begin
        want = bins_due.pop_front();
        bins_seen++;
        if (bin_ch.bin_index !== want.idx) begin
          $error("bin_index: expected %0d, got %0d", want.idx, bin_ch.bin_index);
          errs++;
        end
        if (bin_ch.bin_value !== want.val) begin
          $error("bin_value: expected %0d, got %0d", want.val, bin_ch.bin_value);
          errs++;
        end
        if (bin_ch.last_bin !== want.lst) begin
          $error("last_bin: expected %0d, got %0d", want.lst, bin_ch.last_bin);
          errs++;
        end
      end
    end
  end

  // Watchdog: ends the run when no item moves for too long
  initial begin
    int quiet;
    quiet = 0;
    wait (rst_n === 1'b1);
    while (quiet < WD_LIMIT) begin
      @(negedge clk);
      if ((pix_ch.valid && pix_ch.ready) || (bin_ch.valid && bin_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no item moved for %0d cycles, %0d bin items outstanding", WD_LIMIT,
             bins_due.size());
    $display("DONE: errors detected");
    $finish;
  end

  // Stimulus
  initial begin
    int unsigned n, r;
    int sent;
    logic [ANGLE_W-1:0] ang;
    logic [MAG_W-1:0]   mag;
    logic               lst;

    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_wdata         <= 1'b0;
    pix_ch.valid      <= 1'b0;
    pix_ch.angle      <= '0;
    pix_ch.magnitude  <= '0;
    pix_ch.last_pixel <= 1'b0;
    calm = 1'b0;
    errs = 0;
    pixels = 0;
    bins_seen = 0;
    split_reads = 0;
    near_reads = 0;
    mode_q = MODE_SPLIT;
    for (int i = 0; i < NB; i++) hist[i] = '0;

    dir_tab = '{
      // whole magnitude on the center of bin 0, straight after reset
      '{MODE_SPLIT,   0,     65535, 1, 1, 0, 65535},
      // center of bin 1: no side share
      '{MODE_SPLIT,   2880,  65535, 1, 1, 1, 65535},
      // upper edge of bin 0 stays in bin 0
      '{MODE_SPLIT,   1440,  1000,  1, 0, 0, 0},
      // upper edge of bin 1 moves on to bin 2
      '{MODE_SPLIT,   4320,  777,   0, 0, 0, 0},
      // lower edge of bin 0
      '{MODE_SPLIT,   21600, 1234,  0, 0, 0, 0},
      '{MODE_SPLIT,   23039, 65535, 0, 0, 0, 0},
      // out of range angles wrap back by one circle
      '{MODE_SPLIT,   23040, 100,   0, 0, 0, 0},
      '{MODE_SPLIT,   32767, 65535, 0, 0, 0, 0},
      '{MODE_SPLIT,   12345, 0,     1, 0, 0, 0},
      '{MODE_NEAREST, 0,     65535, 0, 0, 0, 0},
      '{MODE_NEAREST, 1440,  65535, 0, 0, 0, 0},
      '{MODE_NEAREST, 4320,  3,     0, 0, 0, 0},
      '{MODE_NEAREST, 21600, 5,     0, 0, 0, 0},
      '{MODE_NEAREST, 32767, 65535, 1, 0, 0, 0},
      '{MODE_NEAREST, 5760,  43690, 1, 1, 2, 43690},
      '{MODE_SPLIT,   5761,  21845, 0, 0, 0, 0},
      '{MODE_SPLIT,   17279, 65535, 0, 0, 0, 0},
      '{MODE_SPLIT,   16384, 1,     0, 0, 0, 0},
      '{MODE_SPLIT,   20160, 65535, 1, 0, 0, 0}
    };

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part
    foreach (dir_tab[k]) begin
      if (dir_tab[k].mode != mode_q) settle_mode(dir_tab[k].mode);
      if ($urandom_range(0, 3) == 0) idle_for($urandom_range(1, 14));
      push_pixel(dir_tab[k].ang, dir_tab[k].mag, dir_tab[k].lst);
      if (dir_tab[k].lit) begin
        for (int i = 0; i < NB; i++)
          bins_due[bins_due.size() - NB + i].val =
            (i == dir_tab[k].lit_bin) ? dir_tab[k].lit_val : '0;
      end
    end

    // Random part: images of random length, mostly closed by a last pixel
    sent = 0;
    while (sent < RAND_ITEMS) begin
      if (!calm) settle_mode(1'($urandom_range(0, 1)));
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
      for (int k = 0; k < n && sent < RAND_ITEMS; k++) begin
        r = $urandom_range(0, 9);
        if (r == 0) ang = ANGLE_W'($urandom_range(0, 15) * 1440 + $urandom_range(0, 2)) - 1'b1;
        else if (r == 1) ang = ANGLE_W'($urandom_range(ANGLE_FULL, 32767));
        else ang = ANGLE_W'($urandom_range(0, ANGLE_FULL - 1));
        r = $urandom_range(0, 7);
        if (r == 0) mag = '0;
        else if (r == 1) mag = '1;
        else mag = MAG_W'($urandom);
        if (k == n - 1) lst = ($urandom_range(0, 5) != 0);
        else lst = ($urandom_range(0, 15) == 0);
        if (sent >= RAND_ITEMS - CALM_ITEMS) calm = 1'b1;
        if (!calm && $urandom_range(0, 4) == 0) idle_for($urandom_range(1, 14));
        push_pixel(ang, mag, lst);
        sent++;
      end
    end

    // Let the last readout drain
    pix_ch.valid <= 1'b0;
    while (bins_due.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("run covered %0d pixels and %0d checked bin items", pixels, bins_seen);
    $display("readouts: %0d with split binning, %0d with nearest binning", split_reads,
             near_reads);
    if (errs == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/ohsb_pkg.sv
rtl/ohsb_pix_if.sv
rtl/ohsb_bin_if.sv
rtl/orientation_histogram_soft_binning.sv
tb/testbench.sv
